### hdl/mrta_pkg.sv
package mrta_pkg;

  localparam logic [3:0] TYPE_RESERVED = 4'd0;
  localparam logic [3:0] TYPE_RT_CODE = 4'd5;
  localparam logic [3:0] TYPE_RT_DATA = 4'd6;
  localparam logic [3:0] TYPE_FREE = 4'd7;
  localparam logic [3:0] TYPE_ACPI_RECLAIM = 4'd9;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [63:0] ADDR_1MB = 64'h0000_0000_0010_0000;
  localparam logic [63:0] ADDR_4GB = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic        action;
    logic [3:0]  region_type;
    logic [63:0] base_address;
    logic [51:0] page_count;
    logic [63:0] region_attribute;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_address;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  dtype;
    logic [63:0] start;
    logic [51:0] pages;
    logic [63:0] attr;
  } desc_t;

endpackage

### hdl/memory_region_table_allocator_core.sv
// Region descriptor table held in one synchronous memory. One transaction runs at a time.
// An add reads the entries valid at the start (a read state and a modify state per entry,
// plus an append per tail split) and then appends, unless a free entry matches exactly; an
// allocate scans the same way up to the first runtime services entry, then updates the
// chosen entry and, unless it fits exactly, appends a new one. A zero-page request skips
// the scan. The next transaction is taken the cycle after the result leaves the output
// register, so the block takes no new request until the last result has left. No clearing
// pass is needed after reset since entries beyond the count are never read.
module memory_region_table_allocator_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int PAGE_SHIFT = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrta_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mrta_pkg::rsp_t out_data
);
  import mrta_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_APPEND, S_FIX, S_DONE
  } state_t;

  state_t state;
  desc_t mem [TABLE_DEPTH];
  desc_t rd;
  logic [IW-1:0] rd_addr;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  desc_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  req_t req;
  logic [CW-1:0] count;
  logic [CW-1:0] limit;
  logic [CW-1:0] idx;
  logic [1:0] status;
  logic [63:0] found;
  logic best_hit;
  logic [63:0] best_start;
  logic [51:0] best_pages;
  logic [IW-1:0] best;

  // add path per entry
  logic [63:0] diff;
  logic [52:0] need;
  logic [51:0] pages1;
  logic [63:0] np_bytes;
  logic lower, fits, split;
  always_comb begin
    np_bytes = {12'd0, req.page_count} << PAGE_SHIFT;
    diff = req.base_address - rd.start;
    need = 53'(diff >> PAGE_SHIFT) + {1'b0, req.page_count};
    lower = rd.start < req.base_address;
    fits = lower && ({1'b0, rd.pages} >= need);
    split = fits && ({1'b0, rd.pages} > need);
    pages1 = rd.pages;
    if (fits && !(split && count >= CW'(TABLE_DEPTH)))
      pages1 = 52'(need - {1'b0, req.page_count});
  end

  // alloc path per entry
  logic [64:0] end_sum;
  logic carry, cand, skip;
  always_comb begin
    end_sum = {1'b0, rd.start} + {1'b0, 64'({12'd0, rd.pages} << PAGE_SHIFT)};
    carry = end_sum[64];
    skip = !carry && end_sum[63:0] <= ADDR_1MB;
    cand = !skip && rd.dtype == TYPE_FREE && rd.pages >= req.page_count &&
           rd.start > best_start && !carry && end_sum[63:0] <= ADDR_4GB;
  end

  logic [63:0] take_at;
  assign take_at = best_start + 64'({12'd0, 52'(best_pages - req.page_count)} << PAGE_SHIFT);

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = rd;
    rd_addr = idx[IW-1:0];
    case (state)
      S_EVAL: begin
        if (req.action == ACT_ADD && rd.dtype == TYPE_FREE) begin
          wr_en = 1'b1;
          wr_data.pages = pages1;
          if (rd.start == req.base_address && pages1 == req.page_count) begin
            wr_data.dtype = req.region_type;
            wr_data.attr = req.region_attribute;
          end else if (rd.start == req.base_address && pages1 > req.page_count) begin
            wr_data.pages = pages1 - req.page_count;
            wr_data.start = rd.start + np_bytes;
          end
        end
      end
      S_APPEND: begin
        wr_addr = count[IW-1:0];
        if (req.action == ACT_ADD) begin
          wr_en = count < CW'(TABLE_DEPTH);
          if (idx != limit) begin
            wr_data = '{TYPE_FREE, req.base_address + np_bytes,
                        52'(need - {1'b0, req.page_count}) , rd.attr};
            wr_data.pages = rd.pages - 52'(need);
          end else begin
            wr_data = '{req.region_type, req.base_address, req.page_count,
                        req.region_attribute};
          end
        end else begin
          // an exact fit only retypes in place, so it needs no free slot
          wr_en = best_hit && (best_pages == req.page_count || count < CW'(TABLE_DEPTH));
          if (best_pages == req.page_count) begin
            wr_addr = best;
            wr_data = '{req.region_type, best_start, best_pages, req.region_attribute};
          end else begin
            wr_data = '{req.region_type, take_at, req.page_count, req.region_attribute};
          end
        end
      end
      S_FIX: begin
        wr_en = 1'b1;
        wr_addr = best;
        wr_data = '{rd.dtype, best_start, 52'(best_pages - req.page_count), rd.attr};
        rd_addr = best;
      end
      default: ;
    endcase
    if (state == S_APPEND && req.action == ACT_ALLOC) rd_addr = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            idx <= '0;
            limit <= count;
            status <= (in_data.page_count == '0 && in_data.action == ACT_ALLOC) ?
                      ST_NONE : ST_OK;
            found <= '0;
            best_hit <= 1'b0;
            best_start <= '0;
            best_pages <= '0;
            best <= '0;
            if (in_data.page_count == '0) begin
              state <= S_DONE;
            end else begin
              state <= (count == '0) ? S_APPEND : S_READ;
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (req.action == ACT_ADD) begin
            if (rd.dtype == TYPE_FREE && split) begin
              if (count >= CW'(TABLE_DEPTH)) status <= ST_FULL;
              else state <= S_APPEND;
            end
            if (rd.dtype == TYPE_FREE && rd.start == req.base_address &&
                pages1 == req.page_count) begin
              state <= S_DONE;
            end else if (!(rd.dtype == TYPE_FREE && split && count < CW'(TABLE_DEPTH))) begin
              idx <= idx + 1'b1;
              state <= (idx + 1'b1 == limit) ? S_APPEND : S_READ;
            end
          end else begin
            if (cand) begin
              best_hit <= 1'b1;
              best_start <= rd.start;
              best_pages <= rd.pages;
              best <= idx[IW-1:0];
            end
            idx <= idx + 1'b1;
            if (!skip && (rd.dtype == TYPE_RT_CODE || rd.dtype == TYPE_RT_DATA))
              state <= S_APPEND;
            else
              state <= (idx + 1'b1 == limit) ? S_APPEND : S_READ;
          end
        end
        S_APPEND: begin
          if (req.action == ACT_ADD) begin
            if (idx != limit) begin
              // tail split of entry idx appended, continue with same entry
              count <= count + 1'b1;
              state <= S_EVAL;
            end else begin
              if (count < CW'(TABLE_DEPTH)) count <= count + 1'b1;
              else status <= ST_FULL;
              state <= S_DONE;
            end
          end else begin
            if (!best_hit) begin
              status <= ST_NONE;
              state <= S_DONE;
            end else if (best_pages == req.page_count) begin
              found <= best_start;
              state <= S_DONE;
            end else if (count >= CW'(TABLE_DEPTH)) begin
              status <= ST_FULL;
              state <= S_DONE;
            end else begin
              found <= take_at;
              count <= count + 1'b1;
              state <= S_FIX;
            end
          end
        end
        S_FIX: state <= S_DONE;
        S_DONE: begin
          out_data <= '{status, found, 7'(count)};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/testbench.sv
module testbench;
  import mrta_pkg::*;

  localparam int DEPTH = 64;
  localparam int PSHIFT = 12;
  localparam logic [63:0] PMASK = (64'd1 << 52) - 64'd1;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int N_RANDOM = 1400;

  class region_scoreboard;
    logic [3:0]  tbl_type [DEPTH];
    logic [63:0] tbl_start [DEPTH];
    logic [63:0] tbl_pages [DEPTH];
    logic [63:0] tbl_attr [DEPTH];
    int          used;
    rsp_t        pending [$];
    int          errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void put(int k, logic [3:0] t, logic [63:0] s, logic [63:0] p, logic [63:0] a);
      tbl_type[k] = t;
      tbl_start[k] = s;
      tbl_pages[k] = p & PMASK;
      tbl_attr[k] = a;
    endfunction

    function logic [1:0] carve_add(req_t r);
      logic [1:0]  st;
      logic [63:0] np, base, need;
      int          n;
      st = ST_OK;
      np = {12'd0, r.page_count};
      base = r.base_address;
      n = used;
      if (np == 0) return ST_OK;
      for (int i = 0; i < n; i++) begin
        if (tbl_type[i] != TYPE_FREE) continue;
        if (tbl_start[i] < base) begin
          need = ((base - tbl_start[i]) >> PSHIFT) + np;
          if (tbl_pages[i] >= need) begin
            if (tbl_pages[i] > need) begin
              if (used >= DEPTH) begin
                st = ST_FULL;
              end else begin
                put(used, TYPE_FREE, base + (np << PSHIFT), tbl_pages[i] - need, tbl_attr[i]);
                used++;
                tbl_pages[i] = (need - np) & PMASK;
              end
            end else begin
              tbl_pages[i] = (need - np) & PMASK;
            end
          end
        end
        if (tbl_start[i] == base && tbl_pages[i] == np) begin
          tbl_type[i] = r.region_type;
          tbl_attr[i] = r.region_attribute;
          return st;
        end
        if (tbl_start[i] == base && tbl_pages[i] > np) begin
          tbl_pages[i] = tbl_pages[i] - np;
          tbl_start[i] = tbl_start[i] + (np << PSHIFT);
        end
      end
      if (used >= DEPTH) return ST_FULL;
      put(used, r.region_type, base, np, r.region_attribute);
      used++;
      return st;
    endfunction

    function logic [1:0] take_top(req_t r, output logic [63:0] addr);
      logic [63:0] np, best_start, best_pages, len, fin, at;
      logic        carry;
      int          best;
      logic [3:0]  t;
      addr = 0;
      np = {12'd0, r.page_count};
      best_start = 0;
      best_pages = 0;
      best = 0;
      if (np == 0) return ST_NONE;
      for (int i = 0; i < used; i++) begin
        len = tbl_pages[i] << PSHIFT;
        fin = tbl_start[i] + len;
        carry = fin < tbl_start[i];
        t = tbl_type[i];
        if (!carry && fin <= ADDR_1MB) continue;
        if (t == TYPE_FREE && tbl_pages[i] >= np && tbl_start[i] > best_start &&
            !carry && fin <= ADDR_4GB) begin
          best_start = tbl_start[i];
          best_pages = tbl_pages[i];
          best = i;
        end
        if (t == TYPE_RESERVED || t >= TYPE_ACPI_RECLAIM) continue;
        if (t == TYPE_RT_CODE || t == TYPE_RT_DATA) break;
      end
      if (best_start == 0) return ST_NONE;
      if (best_pages != np) begin
        at = best_start + ((best_pages - np) << PSHIFT);
        if (used >= DEPTH) return ST_FULL;
        tbl_pages[best] = (best_pages - np) & PMASK;
        put(used, r.region_type, at, np, r.region_attribute);
        used++;
        addr = at;
      end else begin
        tbl_type[best] = r.region_type;
        tbl_attr[best] = r.region_attribute;
        addr = best_start;
      end
      return ST_OK;
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      logic [63:0] a;
      a = 0;
      if (r.action == ACT_ADD) e.status = carve_add(r);
      else e.status = take_top(r, a);
      e.found_address = a;
      e.entry_count = used[6:0];
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.found_address !== e.found_address ||
          got.entry_count !== e.entry_count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected st=%0d addr=%h cnt=%0d, got st=%0d addr=%h cnt=%0d",
                   e.status, e.found_address, e.entry_count,
                   got.status, got.found_address, got.entry_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  region_scoreboard sb;
  int cycles;
  int results_seen;
  int stall_left;

  memory_region_table_allocator_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    sb = new();
  end

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL memory_region_table_allocator_core");
      $finish;
    end
  end

  initial cycles = 0;
  initial results_seen = 0;
  initial stall_left = 0;

  // receiver: own stall pattern plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_response(out_data);
        results_seen <= results_seen + 1;
        if (results_seen == 300) stall_left <= 3000;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 0;
      end else if ((cycles / 64) % 4 == 3) begin
        out_ready <= 1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_req(logic act, logic [3:0] t, logic [63:0] b,
                                    logic [51:0] p, logic [63:0] a);
    req_t r;
    r.action = act;
    r.region_type = t;
    r.base_address = b;
    r.page_count = p;
    r.region_attribute = a;
    return r;
  endfunction

  task automatic send_request(req_t r);
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] grid_base();
    return 64'h0010_0000 + ({52'd0, 12'($urandom_range(0, 255))} << PSHIFT);
  endfunction

  initial begin
    req_t r;
    int   k;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: free pool, carving, exact match, zero pages, wrap and stop cases
    send_request(make_req(ACT_ADD, TYPE_FREE, 64'h0010_0000, 52'd256, 64'h0));
    send_request(make_req(ACT_ADD, 4'd1, 64'h0012_0000, 52'd0, 64'h1));
    send_request(make_req(ACT_ALLOC, 4'd2, 64'h0, 52'd0, 64'h2));
    send_request(make_req(ACT_ALLOC, 4'd2, 64'h0, 52'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(ACT_ADD, 4'd3, 64'h0012_0000, 52'd4, 64'h3));
    send_request(make_req(ACT_ADD, 4'd4, 64'h0010_0000, 52'd2, 64'h4));
    send_request(make_req(ACT_ADD, TYPE_FREE, 64'h2000_0000, 52'd16, 64'h5));
    send_request(make_req(ACT_ADD, 4'd1, 64'h2000_0000, 52'd16, 64'h6));
    send_request(make_req(ACT_ADD, TYPE_FREE, 64'h3000_0000, 52'd4, 64'h7));
    send_request(make_req(ACT_ALLOC, 4'd8, 64'h0, 52'd4, 64'h8));
    send_request(make_req(ACT_ADD, TYPE_FREE, 64'hFFFF_F000, 52'd1, 64'h9));
    send_request(make_req(ACT_ADD, TYPE_RT_CODE, 64'h0000_1000, 52'd512, 64'hA));
    send_request(make_req(ACT_ADD, TYPE_FREE, 64'h8000_0000, 52'd32, 64'hB));
    send_request(make_req(ACT_ALLOC, 4'd2, 64'h0, 52'd1, 64'hC));
    send_request(make_req(ACT_ADD, TYPE_FREE, 64'hFFFF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(ACT_ALLOC, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF,
                          64'h0));
    send_request(make_req(ACT_ADD, TYPE_ACPI_RECLAIM, 64'h0, 52'd1, 64'h0));
    send_request(make_req(ACT_ALLOC, 4'd1, 64'h0, 52'd2, 64'h1));
    in_valid <= 0;
    repeat (20) @(posedge clk);
    // random: mostly carving and allocation on a small page grid, some noise
    for (k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: r = make_req(ACT_ALLOC, 4'($urandom_range(0, 15)), rand64(),
                              52'($urandom_range(0, 24)), rand64());
        3, 4: r = make_req(ACT_ADD, TYPE_FREE, grid_base(),
                           52'($urandom_range(1, 64)), rand64());
        5, 6, 7: r = make_req(ACT_ADD, 4'($urandom_range(0, 15)), grid_base(),
                              52'($urandom_range(0, 16)), rand64());
        8: r = make_req(ACT_ALLOC, 4'($urandom_range(0, 15)), rand64(),
                        52'($urandom_range(1, 4)), rand64());
        default: r = make_req(1'($urandom), 4'($urandom), rand64(),
                              52'(rand64()), rand64());
      endcase
      send_request(r);
      maybe_gap();
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS memory_region_table_allocator_core");
    end else begin
      $display("FAIL memory_region_table_allocator_core");
    end
    $finish;
  end

endmodule
